// File: design/swhc_pkg.sv
// Shared types and constants for the sliding window hit counter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package swhc_pkg;

	// Field widths of the item channels and of the window register.
	localparam int STAMP_W = 31;
	localparam int COUNT_W = 32;
	localparam int WIN_W   = 10;

	// Reset value of the window register, in seconds.
	localparam logic [WIN_W-1:0] WINDOW_RESET = 10'd300;

	// Default number of one-second buckets in the ring.
	localparam int BUCKET_DEPTH_DEF = 512;

	// Request codes carried by req_type.
	localparam logic REQ_HIT   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Largest count; bucket counts and window sums saturate here.
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// One bucket of the ring: the second it counts and its hit count.
	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [COUNT_W-1:0] count;
	} bucket_t;

endpackage

`default_nettype wire

// File: design/swhc_slot_mod.sv
// Remainder unit: timestamp modulo the bucket depth by reciprocal multiplication, three stages.
// Depends on swhc_pkg for the timestamp width.
`default_nettype none

module swhc_slot_mod
	import swhc_pkg::*;
#(
	parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [STAMP_W-1:0]              dividend,
	output logic                                 done,
	output logic [$clog2(BUCKET_DEPTH)-1:0]      slot
);

	localparam int IDX_W = $clog2(BUCKET_DEPTH);
	localparam int SHIFT = STAMP_W + IDX_W;
	localparam int PROD_W = STAMP_W + 32;
	// floor(2^SHIFT / depth) always fits in 32 bits because the depth exceeds 2^(IDX_W-1).
	localparam logic [31:0] RECIP = 32'((longint'(1) << SHIFT) / longint'(BUCKET_DEPTH));
	localparam logic [STAMP_W-1:0] DEPTH_S = STAMP_W'(BUCKET_DEPTH);
	localparam logic [IDX_W:0]     DEPTH_R = (IDX_W+1)'(BUCKET_DEPTH);

	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic [STAMP_W-1:0] t_s1;
	logic [STAMP_W-1:0] t_s2;
	logic [STAMP_W-1:0] quo_s2;
	logic [IDX_W:0]     rem_s3;
	logic [PROD_W-1:0]  prod;
	logic [STAMP_W-1:0] rem_full;
	logic [IDX_W:0]     rem_adj;

	// The quotient estimate is at most one short, so the remainder is below twice the depth
	// and a single compare and subtract finishes it.
	always_comb begin
		prod     = {32'b0, t_s1} * {{(PROD_W-32){1'b0}}, RECIP};
		rem_full = t_s2 - quo_s2 * DEPTH_S;
		rem_adj  = (rem_s3 >= DEPTH_R) ? (rem_s3 - DEPTH_R) : rem_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			t_s1 <= dividend;
		end
		if (valid_s1) begin
			t_s2   <= t_s1;
			quo_s2 <= STAMP_W'(prod >> SHIFT);
		end
		if (valid_s2) begin
			rem_s3 <= rem_full[IDX_W:0];
		end
	end

	assign done = valid_s3;
	assign slot = rem_adj[IDX_W-1:0];

endmodule

`default_nettype wire

// File: design/swhc_bucket_ram.sv
// Bucket ring storage: one write port and one registered read port.
// Depends on swhc_pkg for the bucket type.
`default_nettype none

module swhc_bucket_ram
	import swhc_pkg::*;
#(
	parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            we,
	input  wire logic [$clog2(BUCKET_DEPTH)-1:0] waddr,
	input  wire bucket_t                         wdata,
	input  wire logic                            re,
	input  wire logic [$clog2(BUCKET_DEPTH)-1:0] raddr,
	output bucket_t                              rdata
);

	bucket_t mem [BUCKET_DEPTH];
	bucket_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/sliding_window_hit_counter.sv
// Sliding window hit counter, top level: control sequencer and window register.
// Depends on swhc_pkg, swhc_slot_mod and swhc_bucket_ram.
//
// The block counts events over a sliding window of window_seconds seconds. An item with
// req_type REQ_HIT records one event at its timestamp; an item with req_type REQ_QUERY returns,
// on the output channel, the number of recorded hits whose stamp plus the window exceeds the
// query time, saturating at all ones. Hits live in a ring of BUCKET_DEPTH one-second buckets
// held in a single-port-read synchronous memory, slot = timestamp modulo the depth; a hit
// older than the newest hit seen is dropped, and a window longer than the ring acts as the
// ring length. After reset the block sweeps the memory to zero, one bucket a cycle, and
// accepts no item until that sweep ends; the window register may be written at any time
// during that sweep. One item is in work at a time. A hit keeps the block busy after its
// acceptance through the remainder unit, which works by reciprocal multiplication, then a
// read and a write-back of its bucket; the next item can be taken once that write-back is
// done. A stale hit is dropped at once and the next item can follow directly.
// A query keeps the block busy until its result, set by the sweep that reads every bucket
// through the one memory read port, has moved into the output register, and the next item
// can be taken from then on. The result is held in an output register; a further query can be
// accepted while that result still waits, but it cannot finish until the register has been
// taken. The window register should only be written while no item is in work.
`default_nettype none

module sliding_window_hit_counter
	import swhc_pkg::*;
#(
	parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               req_type,
	input  wire logic [STAMP_W-1:0] timestamp,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [COUNT_W-1:0]      hit_count,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [WIN_W-1:0]   window_seconds
);

	localparam int IDX_W = $clog2(BUCKET_DEPTH);
	localparam int CTR_W = IDX_W + 1;
	localparam int WC_W  = (WIN_W > CTR_W) ? WIN_W : CTR_W;
	localparam logic [CTR_W-1:0] DEPTH_CTR = CTR_W'(BUCKET_DEPTH);
	localparam logic [WC_W-1:0]  DEPTH_WC  = WC_W'(BUCKET_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BUCKET_DEPTH - 1);

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_MOD    = 7'b0000100,
		ST_HIT_RD = 7'b0001000,
		ST_HIT_WR = 7'b0010000,
		ST_QUERY  = 7'b0100000,
		ST_QDONE  = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [WIN_W-1:0]   window_q;
	logic [STAMP_W-1:0] latest_q;
	logic [STAMP_W-1:0] t_q;
	logic [WC_W-1:0]    win_q;
	logic [IDX_W-1:0]   clr_idx_q;
	logic [CTR_W-1:0]   rd_idx_q;
	logic               rvalid_s1;
	logic [COUNT_W-1:0] sum_q;
	logic [IDX_W-1:0]   slot_q;
	logic               out_valid_q;
	logic [COUNT_W-1:0] hit_count_q;

	logic               in_acc;
	logic               mod_start;
	logic               mod_done;
	logic [IDX_W-1:0]   mod_slot;
	logic               issue;
	logic               result_load;
	logic [WC_W-1:0]    win_clamped;
	logic               in_window;
	logic [COUNT_W:0]   sum_add;
	logic [COUNT_W-1:0] sum_next;
	logic [COUNT_W-1:0] count_inc;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	bucket_t            ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	bucket_t            ram_rdata;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign hit_count = hit_count_q;

	// A hit goes to the remainder unit only if it is not older than the newest hit.
	assign mod_start = in_acc && (req_type == REQ_HIT) && (timestamp >= latest_q);

	// A finished query moves its sum to the output register once that register is free.
	assign result_load = (state_q == ST_QDONE) && (!out_valid_q || out_ready);

	// The ring never holds more seconds than its depth, so the window is clamped to it.
	always_comb begin
		win_clamped = WC_W'(window_q);
		if (win_clamped > DEPTH_WC) begin
			win_clamped = DEPTH_WC;
		end
	end

	// Sweep step: a bucket adds to the sum when its stamp plus the window passes the query time.
	always_comb begin
		issue     = (state_q == ST_QUERY) && (rd_idx_q != DEPTH_CTR);
		in_window = ({1'b0, ram_rdata.stamp} + (STAMP_W+1)'(win_q)) > {1'b0, t_q};
		sum_add   = {1'b0, sum_q} + {1'b0, ram_rdata.count};
		sum_next  = sum_add[COUNT_W] ? COUNT_MAX : sum_add[COUNT_W-1:0];
		count_inc = (ram_rdata.count == COUNT_MAX) ? COUNT_MAX : (ram_rdata.count + 1'b1);
	end

	// Memory port selection. Writes come from the clearing sweep or a hit write-back only.
	always_comb begin
		ram_we          = 1'b0;
		ram_waddr       = slot_q;
		ram_wdata.stamp = t_q;
		ram_wdata.count = (ram_rdata.stamp == t_q) ? count_inc : COUNT_W'(1);
		ram_re          = 1'b0;
		ram_raddr       = rd_idx_q[IDX_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				ram_wdata = '0;
			end
			ST_HIT_RD: begin
				ram_re    = 1'b1;
				ram_raddr = slot_q;
			end
			ST_HIT_WR: begin
				ram_we = 1'b1;
			end
			ST_QUERY: begin
				ram_re = issue;
			end
			default: begin
			end
		endcase
	end

	// Window register; the only configuration register, written whenever offered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= window_seconds;
		end
	end

	// Sequencer and control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			rd_idx_q    <= '0;
			rvalid_s1   <= 1'b0;
			latest_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= issue;
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						if (req_type == REQ_QUERY) begin
							rd_idx_q <= '0;
							state_q  <= ST_QUERY;
						end else if (mod_start) begin
							latest_q <= timestamp;
							state_q  <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						state_q <= ST_HIT_RD;
					end
				end
				ST_HIT_RD: begin
					state_q <= ST_HIT_WR;
				end
				ST_HIT_WR: begin
					state_q <= ST_IDLE;
				end
				ST_QUERY: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end else if (!rvalid_s1) begin
						state_q <= ST_QDONE;
					end
				end
				ST_QDONE: begin
					// The result waits here until the output register is free.
					if (result_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request time, window, slot, running sum and the result.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			t_q   <= timestamp;
			win_q <= win_clamped;
			sum_q <= '0;
		end else if (rvalid_s1 && in_window) begin
			sum_q <= sum_next;
		end
		if (mod_done) begin
			slot_q <= mod_slot;
		end
		if (result_load) begin
			hit_count_q <= sum_q;
		end
	end

	swhc_slot_mod #(
		.BUCKET_DEPTH (BUCKET_DEPTH)
	) u_slot_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (timestamp),
		.done     (mod_done),
		.slot     (mod_slot)
	);

	swhc_bucket_ram #(
		.BUCKET_DEPTH (BUCKET_DEPTH)
	) u_bucket_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The memory is only ever written by the clearing sweep or a hit write-back.
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == ST_CLEAR) || (state_q == ST_HIT_WR)))
		else $error("bucket memory written outside clearing or hit write-back");

	// Read data for the sum only arrives while the sweep is running.
	a_sweep_data: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_s1 |-> (state_q == ST_QUERY))
		else $error("sweep read data outside the query sweep");

	// The newest hit stamp never moves backwards.
	a_latest_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (latest_q >= $past(latest_q)))
		else $error("latest hit stamp decreased");

	// A query only finishes after every bucket has been read.
	a_sweep_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QDONE) |-> (rd_idx_q == DEPTH_CTR))
		else $error("query finished before the sweep covered the ring");

endmodule

`default_nettype wire
